/* rtl/cbx_pkg.sv */
package cbx_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 24;
  localparam int U_W     = FRAC_W + 1;
  localparam int W_W     = FRAC_W + 2;
  localparam int PROD_W  = COORD_W + W_W;
  localparam int RND_W   = PROD_W - FRAC_W;
  localparam int ACC_W   = COORD_W + 4;
  localparam int DIFF_W  = COORD_W + 2;
  localparam int NUM_REGS = 8;
  localparam int ADDR_W  = 5;
  localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_W;
  localparam logic signed [DIFF_W-1:0] MARGIN_LSB = DIFF_W'(66);

  typedef struct packed {
    logic           start;
    logic [U_W-1:0] u;
  } eval_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] value;
  } eval_rsp_t;

endpackage

/* rtl/cbx_eval.sv */
// Evaluates one coordinate of the curve at u on a single shared multiplier.
// Ten products in sequence: u*u, s*s, u2*u, s2*s, u*s2, u2*s and four terms.
module cbx_eval (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cbx_pkg::eval_req_t                     req,
  input  logic [3:0][cbx_pkg::COORD_W-1:0]       coord,
  output cbx_pkg::eval_rsp_t                     rsp
);

  localparam logic [3:0] LAST_OP = 4'd9;
  localparam logic [3:0] FINISH  = 4'd11;
  localparam logic signed [cbx_pkg::ACC_W-1:0] ACC_MAX =
    {{(cbx_pkg::ACC_W-cbx_pkg::COORD_W+1){1'b0}}, {(cbx_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [cbx_pkg::ACC_W-1:0] ACC_MIN = ~ACC_MAX;

  logic                         busy_r;
  logic [3:0]                   cnt_r;
  logic [cbx_pkg::U_W-1:0]      u_r, s_r, u2_r, s2_r;
  logic [3:0][cbx_pkg::W_W-1:0] w_r;
  logic [cbx_pkg::PROD_W-1:0]   prod_r;
  logic signed [cbx_pkg::ACC_W-1:0] acc_r;
  logic                         done_r;
  logic signed [cbx_pkg::COORD_W-1:0] value_r;

  logic [cbx_pkg::COORD_W-1:0]  opa;
  logic [cbx_pkg::W_W-1:0]      opb;
  logic [1:0]                   tidx, widx;
  logic [cbx_pkg::COORD_W-1:0]  cmag;
  logic [cbx_pkg::RND_W-1:0]    rnd;
  logic signed [cbx_pkg::ACC_W-1:0] term;
  logic [3:0]                   tsel, wsel;

  assign tsel = cnt_r - 4'd6;
  assign wsel = cnt_r - 4'd7;
  assign tidx = tsel[1:0];
  assign widx = wsel[1:0];
  assign cmag = coord[tidx][cbx_pkg::COORD_W-1] ? (~coord[tidx] + 1'b1) : coord[tidx];

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cnt_r)
      4'd0: begin opa = cbx_pkg::COORD_W'(u_r);  opb = cbx_pkg::W_W'(u_r); end
      4'd1: begin opa = cbx_pkg::COORD_W'(s_r);  opb = cbx_pkg::W_W'(s_r); end
      4'd2: begin opa = cbx_pkg::COORD_W'(u2_r); opb = cbx_pkg::W_W'(u_r); end
      4'd3: begin opa = cbx_pkg::COORD_W'(s2_r); opb = cbx_pkg::W_W'(s_r); end
      4'd4: begin opa = cbx_pkg::COORD_W'(u_r);  opb = cbx_pkg::W_W'(s2_r); end
      4'd5: begin opa = cbx_pkg::COORD_W'(u2_r); opb = cbx_pkg::W_W'(s_r); end
      4'd6, 4'd7, 4'd8, 4'd9: begin opa = cmag; opb = w_r[tidx]; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Round half up at the binary point of u.
  assign rnd = cbx_pkg::RND_W'((prod_r + (cbx_pkg::PROD_W'(1) << (cbx_pkg::FRAC_W - 1)))
                               >> cbx_pkg::FRAC_W);
  // Terms round by magnitude, so the sign goes back on afterward.
  assign term = coord[widx][cbx_pkg::COORD_W-1] ? -cbx_pkg::ACC_W'(rnd)
                                                : cbx_pkg::ACC_W'(rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == FINISH) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      u_r   <= req.u;
      s_r   <= cbx_pkg::U_ONE - req.u;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= LAST_OP) begin
        prod_r <= cbx_pkg::PROD_W'(opa) * cbx_pkg::PROD_W'(opb);
      end
      unique case (cnt_r)
        4'd1: u2_r <= rnd[cbx_pkg::U_W-1:0];
        4'd2: s2_r <= rnd[cbx_pkg::U_W-1:0];
        4'd3: w_r[3] <= rnd[cbx_pkg::W_W-1:0];
        4'd4: w_r[0] <= rnd[cbx_pkg::W_W-1:0];
        4'd5: w_r[1] <= cbx_pkg::W_W'(rnd * 2'd3);
        4'd6: w_r[2] <= cbx_pkg::W_W'(rnd * 2'd3);
        4'd7, 4'd8, 4'd9, 4'd10: acc_r <= acc_r + term;
        default: begin end
      endcase
      if (cnt_r == FINISH) begin
        if (acc_r > ACC_MAX)
          value_r <= {1'b0, {(cbx_pkg::COORD_W-1){1'b1}}};
        else if (acc_r < ACC_MIN)
          value_r <= {1'b1, {(cbx_pkg::COORD_W-1){1'b0}}};
        else
          value_r <= acc_r[cbx_pkg::COORD_W-1:0];
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule

/* rtl/cubic_bezier_x_intersect.sv */
// Finds where a cubic Bezier curve crosses the vertical line x = query and
// returns the curve's y there. The four control points are Q16.16 registers
// on the APB-style port (ctrl0_x at byte 0 through ctrl3_y at byte 28); they
// may be written only while no word is in flight. Each input word runs a
// bisection over u in [0,1] (Q1.24): one curve evaluation at u = 0, then one
// per halving until |x(mid) - query| < 66 LSBs, plus one more for y on a hit.
// Every evaluation runs on one shared 32x26 multiplier. x at the low end is
// carried from the previous halving rather than recomputed. A miss after
// MAX_TRIALS halvings reports found = 0, y = 0. The result register lets a
// new word be accepted while the last result waits.
module cubic_bezier_x_intersect #(
  parameter int MAX_TRIALS = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [cbx_pkg::COORD_W-1:0] in_query_x,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic signed [cbx_pkg::COORD_W-1:0] out_curve_y,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbx_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int TW = $clog2(MAX_TRIALS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LO   = 5'b00010,
    S_MID  = 5'b00100,
    S_Y    = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [cbx_pkg::NUM_REGS-1:0][cbx_pkg::COORD_W-1:0] regs_r;
  logic [2:0] ridx;

  // Control point registers. Register i sits at byte address 4*i.
  assign ridx   = paddr[4:2];
  assign pready = 1'b1;
  assign prdata = regs_r[ridx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (psel && penable && pwrite) begin
      regs_r[ridx] <= pwdata;
    end
  end

  logic signed [cbx_pkg::COORD_W-1:0] q_r;
  logic [cbx_pkg::U_W-1:0] lo_r, hi_r, lo_nxt, hi_nxt, mid_r;
  logic [cbx_pkg::U_W:0]   sum_nxt;
  logic signed [cbx_pkg::DIFF_W-1:0] dlo_r, diff;
  logic [TW-1:0] trial_r;
  logic sel_r, sel_nxt;
  logic found_r;
  logic signed [cbx_pkg::COORD_W-1:0] y_r;
  logic out_valid_r;

  cbx_pkg::eval_req_t req;
  cbx_pkg::eval_rsp_t rsp;
  logic [3:0][cbx_pkg::COORD_W-1:0] coord;

  // The unit reads the x or y coordinate of each control point.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      coord[i] = regs_r[2 * i + int'(sel_r)];
    end
  end

  cbx_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .coord (coord),
    .rsp   (rsp)
  );

  assign diff = cbx_pkg::DIFF_W'(rsp.value) - cbx_pkg::DIFF_W'(q_r);

  logic hit, keep_left, last_trial, out_free;

  assign hit        = (diff < cbx_pkg::MARGIN_LSB) && (diff > -cbx_pkg::MARGIN_LSB);
  // A zero on either side counts as a sign change and keeps the left half.
  assign keep_left  = ((dlo_r <= 0) && (diff >= 0)) || ((dlo_r >= 0) && (diff <= 0));
  assign last_trial = (trial_r == TW'(MAX_TRIALS - 1));
  assign out_free   = !out_valid_r || !out_stall;

  assign lo_nxt  = keep_left ? lo_r : mid_r;
  assign hi_nxt  = keep_left ? mid_r : hi_r;
  assign sum_nxt = {1'b0, lo_nxt} + {1'b0, hi_nxt};

  always_comb begin
    state_nxt = state_r;
    req.start = 1'b0;
    req.u     = '0;
    sel_nxt   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req.start = 1'b1;
          req.u     = '0;
          sel_nxt   = 1'b0;
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.u     = cbx_pkg::U_ONE >> 1;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        if (rsp.done) begin
          if (hit) begin
            req.start = 1'b1;
            req.u     = mid_r;
            sel_nxt   = 1'b1;
            state_nxt = S_Y;
          end else if (last_trial) begin
            state_nxt = S_DONE;
          end else begin
            req.start = 1'b1;
            req.u     = sum_nxt[cbx_pkg::U_W:1];
          end
        end
      end
      S_Y: begin
        if (rsp.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      if ((state_r == S_DONE) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_r     <= in_query_x;
          lo_r    <= '0;
          hi_r    <= cbx_pkg::U_ONE;
          mid_r   <= cbx_pkg::U_ONE >> 1;
          trial_r <= '0;
          found_r <= 1'b0;
          y_r     <= '0;
        end
      end
      S_LO: begin
        if (rsp.done) dlo_r <= diff;
      end
      S_MID: begin
        if (rsp.done) begin
          if (hit) begin
            found_r <= 1'b1;
          end else begin
            lo_r    <= lo_nxt;
            hi_r    <= hi_nxt;
            mid_r   <= sum_nxt[cbx_pkg::U_W:1];
            trial_r <= trial_r + 1'b1;
            if (!keep_left) dlo_r <= diff;
          end
        end
      end
      S_Y: begin
        if (rsp.done) y_r <= rsp.value;
      end
      S_DONE: begin
        if (out_free) begin
          out_found   <= found_r;
          out_curve_y <= y_r;
        end
      end
      default: begin end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/cbx_checker.sv */
module cbx_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_found,
  input logic signed [cbx_pkg::COORD_W-1:0] out_curve_y,
  input logic                              pready
);

  // A miss always reports y as zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_curve_y == '0))
    else $error("miss reported with nonzero y");

  // After a word is taken the block is busy for the search.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after accept");

  // An accept made while no result is showing must not be followed at once by a result.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> ##1 !out_valid)
    else $error("result too early");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_curve_y) && $stable(out_found)))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind cubic_bezier_x_intersect cbx_checker u_cbx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_found   (out_found),
  .out_curve_y (out_curve_y),
  .pready      (pready)
);

/* bench/cbx_checker.sv */
module cbx_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_query_x,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_found,
  input  logic [31:0] out_curve_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [cbx_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          hits,
  output int          results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIALS = 100;
  localparam longint MARGIN = 66;
  localparam longint unsigned UNIT = 64'd1 << 24;

  typedef struct {
    logic        found;
    logic [31:0] curve_y;
  } crossing_t;

  logic signed [31:0] ctrl_pt [8];
  crossing_t crossings_due [$];

  // Weight product rounded to Q1.24 by adding half an LSB.
  function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 23)) >> 24;
  endfunction

  // Coordinate times weight, rounded by magnitude so halves go away from zero.
  function automatic longint scaled_term(longint c, longint unsigned w);
    longint unsigned mag;
    longint unsigned r;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    r = mul_round(mag, w);
    return (c < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint curve_at(longint unsigned u, int sel);
    longint unsigned s;
    longint unsigned u2;
    longint unsigned s2;
    longint unsigned w [4];
    longint sum;
    s = UNIT - u;
    u2 = mul_round(u, u);
    s2 = mul_round(s, s);
    w[0] = mul_round(s2, s);
    w[1] = 3 * mul_round(u, s2);
    w[2] = 3 * mul_round(u2, s);
    w[3] = mul_round(u2, u);
    sum = 0;
    for (int i = 0; i < 4; i++) sum += scaled_term(longint'(ctrl_pt[2*i+sel]), w[i]);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum;
  endfunction

  function automatic crossing_t bisect(logic signed [31:0] query);
    crossing_t res;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint q;
    longint d0;
    longint d1;
    q = longint'(query);
    lo = 0;
    hi = UNIT;
    for (int t = 0; t < TRIALS; t++) begin
      mid = (lo + hi) >> 1;
      d1 = curve_at(mid, 0) - q;
      if ((d1 < 0 ? -d1 : d1) < MARGIN) begin
        res.found = 1'b1;
        res.curve_y = 32'(curve_at(mid, 1));
        return res;
      end
      d0 = curve_at(lo, 0) - q;
      // A zero difference on either side counts as a sign change: keep the left half.
      if ((d0 <= 0 && d1 >= 0) || (d0 >= 0 && d1 <= 0)) hi = mid;
      else lo = mid;
    end
    res.found = 1'b0;
    res.curve_y = '0;
    return res;
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) ctrl_pt[i] <= '0;
      errors <= 0;
      hits <= 0;
      results <= 0;
      pending <= 0;
      crossings_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) ctrl_pt[paddr[4:2]] <= pwdata;
      if (in_valid && !in_stall) crossings_due.push_back(bisect(in_query_x));
      if (out_valid && !out_stall) begin
        results <= results + 1;
        if (out_found) hits <= hits + 1;
        if (crossings_due.size() == 0) begin
          $display("%t: unexpected word found=%0b y=%h", $time, out_found, out_curve_y);
          errors <= errors + 1;
        end else begin
          want = crossings_due.pop_front();
          if (want.found !== out_found || want.curve_y !== out_curve_y) begin
            $display("%t: mismatch expected found=%0b y=%h, actual found=%0b y=%h",
                     $time, want.found, want.curve_y, out_found, out_curve_y);
            errors <= errors + 1;
          end
        end
      end
      pending <= crossings_due.size();
    end
  end
endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte offsets of the control point registers, one 32-bit register each.
  typedef enum logic [cbx_pkg::ADDR_W-1:0] {
    CTRL0_X = 5'd0,  CTRL0_Y = 5'd4,  CTRL1_X = 5'd8,  CTRL1_Y = 5'd12,
    CTRL2_X = 5'd16, CTRL2_Y = 5'd20, CTRL3_X = 5'd24, CTRL3_Y = 5'd28
  } ctrl_addr_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_query_x = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [31:0] out_curve_y;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [cbx_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending, hits, results;
  logic signed [31:0] curve_pts [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cubic_bezier_x_intersect u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_query_x(in_query_x),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_found), .out_curve_y(out_curve_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cbx_scoreboard u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_query_x(in_query_x),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_found), .out_curve_y(out_curve_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .hits(hits), .results(results)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // One APB write: a setup cycle, then an access cycle that commits the register,
  // then an idle cycle before the bus can be used again.
  task automatic reg_write(ctrl_addr_e addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Loads all four control points. Only called with nothing in flight.
  task automatic load_curve();
    reg_write(CTRL0_X, curve_pts[0]);
    reg_write(CTRL0_Y, curve_pts[1]);
    reg_write(CTRL1_X, curve_pts[2]);
    reg_write(CTRL1_Y, curve_pts[3]);
    reg_write(CTRL2_X, curve_pts[4]);
    reg_write(CTRL2_Y, curve_pts[5]);
    reg_write(CTRL3_X, curve_pts[6]);
    reg_write(CTRL3_Y, curve_pts[7]);
  endtask

  // Offers one query word and holds it until the block takes it. Valid stays
  // high into the next word unless a gap is drawn.
  task automatic send_query(logic [31:0] q);
    int gap;
    in_valid <= 1'b1;
    in_query_x <= q;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for the block to drain before touching the registers again.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // A query that lands between the end points, where a crossing is likely,
  // or now and then any 32-bit value at all.
  function automatic logic [31:0] pick_query();
    longint x0, x3;
    if ($urandom_range(0, 9) < 3) return $urandom;
    x0 = longint'(curve_pts[0]);
    x3 = longint'(curve_pts[6]);
    return 32'(x0 + ((x3 - x0) * longint'($urandom_range(0, 4096))) / 4096
               + longint'($urandom_range(0, 400)) - 200);
  endfunction

  task automatic random_queries(int n);
    for (int i = 0; i < n; i++) send_query(pick_query());
  endtask

  // Monotonic in x so that most queries between the ends find a crossing.
  task automatic monotonic_curve(int span);
    int base;
    base = $signed($urandom_range(0, 2 * span)) - span;
    curve_pts[0] = base;
    curve_pts[2] = base + $urandom_range(0, span);
    curve_pts[4] = curve_pts[2] + $urandom_range(0, span);
    curve_pts[6] = curve_pts[4] + $urandom_range(1, span);
    for (int i = 1; i < 8; i += 2) curve_pts[i] = $urandom;
  endtask

  // Receiver: random stalls, plus one long hold-off that fills the block
  // and pushes back on the sender.
  initial begin
    int hold;
    int cycles;
    hold = 0;
    cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == 30000) begin
        out_stall <= 1'b1;
        repeat (5000) @(posedge clk);
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        hold = pick_gap();
        out_stall <= (hold > 0);
      end
    end
  end

  initial begin
    #25ms;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset curve is flat at zero: only queries within the margin of zero hit.
    send_query(32'd0);
    send_query(32'd65);
    send_query(32'd66);
    send_query(-32'sd65);
    send_query(-32'sd66);
    send_query(32'h7fffffff);
    send_query(32'h80000000);
    send_query(32'hffffffff);
    drain();

    // A rising curve; a query at the start point makes the low-side
    // difference exactly zero while the midpoint is far off.
    curve_pts = '{0, 32'h00010000, 32'h000a0000, 32'h7fffffff,
                  32'h00140000, 32'h80000000, 32'h001e0000, 32'h12345678};
    load_curve();
    send_query(32'd0);
    send_query(32'h001e0000);
    send_query(32'h000f0000);
    send_query(32'h001f0000);
    send_query(-32'sd100);
    send_query(32'h55555555);
    send_query(32'haaaaaaaa);
    random_queries(40);
    drain();

    // Extreme coordinates drive the weighted sum into saturation.
    curve_pts = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
    load_curve();
    send_query(32'h80000000);
    send_query(32'h7fffffff);
    send_query(32'd0);
    random_queries(30);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase % 3 == 2) begin
        for (int i = 0; i < 8; i++) curve_pts[i] = $urandom;
      end else begin
        monotonic_curve(phase < 3 ? 32'h00400000 : 32'h20000000);
      end
      load_curve();
      random_queries(70);
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Ran %0d queries over 9 curve settings, saturated ones included.", results);
    $display("%0d queries found a crossing, %0d missed.", hits, results - hits);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

/* cubic_bezier_x_intersect.f */
rtl/cbx_pkg.sv
rtl/cbx_eval.sv
rtl/cubic_bezier_x_intersect.sv
rtl/cbx_checker.sv
bench/cbx_checker.sv
bench/tb.sv
